>>> rtl/bitstream_frame_relocator_macros.svh
// Assertion macros for the assertion file of the frame relocator.
`ifndef BITSTREAM_FRAME_RELOCATOR_MACROS_SVH
`define BITSTREAM_FRAME_RELOCATOR_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define BFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define BFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define BFR_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bfr_pkg.sv
`default_nettype none

package bfr_pkg;

    localparam int WORD_W       = 32;
    localparam int CFG_W        = 3;
    localparam int OP_W         = 2;
    localparam int LOAD_SLOT_W  = 3;
    localparam int LOAD_INDEX_W = 13;
    localparam int SLOT_W       = 6;
    localparam int COUNT_W      = 24;
    localparam int ROW_SHIFT    = 18;

    localparam int SLOT_COUNT_DEF            = 8;
    localparam int CLOCK_WORDS_PER_SLOT_DEF  = 8192;
    localparam int FRAME_WORDS_DEF           = 93;
    localparam int CLOCK_WORDS_PER_FRAME_DEF = 3;
    localparam int QUEUE_DEPTH               = 4;

    localparam logic [OP_W-1:0] OP_STREAM = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_FAR   = 2'd1;
    localparam logic [1:0] PEND_COUNT = 2'd2;
    localparam logic [1:0] PEND_ID    = 2'd3;

    localparam logic [WORD_W-1:0] CMD_FAR          = 32'h3000_2001;
    localparam logic [WORD_W-1:0] CMD_FDRI         = 32'h3000_4000;
    localparam logic [WORD_W-1:0] CMD_DEVICE_ID    = 32'h3001_8001;
    localparam logic [WORD_W-1:0] FDRI_HDR_MASK    = 32'hFFFF_C000;
    localparam logic [WORD_W-1:0] ROW_KEEP_MASK    = 32'hFF03_FFFF;
    localparam logic [WORD_W-1:0] FAR_END_MARK     = 32'h07FC_0000;
    localparam logic [WORD_W-1:0] ID_PART_A        = 32'h0484_A093;
    localparam logic [WORD_W-1:0] ID_PART_B        = 32'h04A4_2093;
    localparam logic [WORD_W-1:0] TYPE1_COUNT_MASK = 32'h0000_03FF;
    localparam logic [WORD_W-1:0] TYPE2_COUNT_MASK = 32'h00FF_FFFF;

    localparam logic [SLOT_W-1:0] ID_A_SLOT_OFFSET = 6'd3;

    typedef logic [WORD_W-1:0] t_word;

    // Classification of one queued request
    typedef struct packed {
        logic is_load;
        logic rd_clk;
        logic far;
        logic fault;
    } t_qflags;

endpackage

`default_nettype wire

>>> rtl/bfr_ram.sv
`default_nettype none

module bfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/bfr_front.sv
`default_nettype none

module bfr_front #(
    parameter int SLOT_COUNT            = 8,
    parameter int CLOCK_WORDS_PER_SLOT  = 8192,
    parameter int FRAME_WORDS           = 93,
    parameter int CLOCK_WORDS_PER_FRAME = 3,
    parameter int ADDR_W                = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [bfr_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [bfr_pkg::OP_W-1:0]            i_operation,
    input  wire logic [bfr_pkg::WORD_W-1:0]          i_word,
    input  wire logic [bfr_pkg::LOAD_SLOT_W-1:0]     i_load_slot,
    input  wire logic [bfr_pkg::LOAD_INDEX_W-1:0]    i_load_index,
    input  wire logic                                i_q_full,
    output logic                                     o_push,
    output bfr_pkg::t_qflags                         o_flags,
    output logic [bfr_pkg::WORD_W-1:0]               o_word,
    output logic [ADDR_W-1:0]                        o_addr
);
    import bfr_pkg::*;

    localparam int CI_W  = $clog2(CLOCK_WORDS_PER_SLOT);
    localparam int WIF_W = $clog2(FRAME_WORDS);
    localparam int WIN_LO = (FRAME_WORDS - CLOCK_WORDS_PER_FRAME) / 2;
    localparam int WIN_HI = WIN_LO + CLOCK_WORDS_PER_FRAME;

    logic [CFG_W-1:0]   r_start_slot;
    logic [SLOT_W-1:0]  r_next_slot, n_next_slot;
    logic [SLOT_W-1:0]  r_cur_slot,  n_cur_slot;
    logic [1:0]         r_pend,      n_pend;
    logic [COUNT_W-1:0] r_rem,       n_rem;
    logic [WIF_W-1:0]   r_wif,       n_wif;
    logic [CI_W-1:0]    r_ci,        n_ci;

    logic              accept;
    logic              in_frame;
    logic              in_window;
    logic              slot_ok;
    logic              load_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // Remaining count holds whole frames while it is at least one frame long
    assign in_frame  = r_rem >= COUNT_W'(FRAME_WORDS);
    assign in_window = (r_wif >= WIF_W'(WIN_LO)) && (r_wif < WIF_W'(WIN_HI));
    assign slot_ok   = 32'(r_cur_slot) < SLOT_COUNT;
    assign load_ok   = (32'(i_load_slot) < SLOT_COUNT)
                    && (32'(i_load_index) < CLOCK_WORDS_PER_SLOT);

    assign rd_addr = ADDR_W'(r_cur_slot) * ADDR_W'(CLOCK_WORDS_PER_SLOT) + ADDR_W'(r_ci);
    assign wr_addr = ADDR_W'(i_load_slot) * ADDR_W'(CLOCK_WORDS_PER_SLOT)
                   + ADDR_W'(i_load_index);

    always_comb begin
        n_next_slot = r_next_slot;
        n_cur_slot  = r_cur_slot;
        n_pend      = r_pend;
        n_rem       = r_rem;
        n_wif       = r_wif;
        n_ci        = r_ci;
        o_push      = 1'b0;
        o_flags     = '0;
        o_word      = i_word;
        o_addr      = '0;

        if (accept) begin
            unique case (i_operation)
                OP_STREAM: begin
                    o_push = 1'b1;
                    priority if (in_frame) begin
                        if (in_window) begin
                            if (slot_ok) begin
                                o_flags.rd_clk = 1'b1;
                                o_addr         = rd_addr;
                            end else begin
                                o_flags.fault = 1'b1;
                            end
                            n_ci = (r_ci == CI_W'(CLOCK_WORDS_PER_SLOT - 1)) ? '0
                                 : r_ci + 1'b1;
                        end
                        if (r_wif == WIF_W'(FRAME_WORDS - 1)) begin
                            n_wif = '0;
                            n_rem = r_rem - COUNT_W'(FRAME_WORDS);
                        end else begin
                            n_wif = r_wif + 1'b1;
                        end
                    end else if (r_pend == PEND_ID) begin
                        n_pend = PEND_NONE;
                        if (i_word == ID_PART_A) begin
                            n_next_slot = r_next_slot + ID_A_SLOT_OFFSET;
                        end else if (i_word != ID_PART_B) begin
                            o_flags.fault = 1'b1;
                        end
                    end else if (r_pend == PEND_FAR) begin
                        n_pend     = PEND_NONE;
                        n_cur_slot = r_next_slot;
                        if (i_word != FAR_END_MARK) begin
                            o_word      = (i_word & ROW_KEEP_MASK)
                                        | (WORD_W'(r_next_slot) << ROW_SHIFT);
                            o_flags.far = 1'b1;
                            n_next_slot = r_next_slot + 1'b1;
                        end
                    end else if (r_pend == PEND_COUNT) begin
                        n_pend = PEND_NONE;
                        n_rem  = COUNT_W'(i_word & TYPE2_COUNT_MASK);
                        n_wif  = '0;
                    end else begin
                        if (i_word == CMD_FAR) begin
                            n_pend = PEND_FAR;
                        end else if ((i_word & FDRI_HDR_MASK) == CMD_FDRI) begin
                            // zero type-1 count: the count follows in a type-2 word
                            if ((i_word & TYPE1_COUNT_MASK) != '0) begin
                                n_rem = COUNT_W'(i_word & TYPE1_COUNT_MASK);
                                n_wif = '0;
                            end else begin
                                n_pend = PEND_COUNT;
                            end
                        end else if (i_word == CMD_DEVICE_ID) begin
                            n_pend = PEND_ID;
                        end
                    end
                end
                OP_LOAD: begin
                    if (load_ok) begin
                        o_push          = 1'b1;
                        o_flags.is_load = 1'b1;
                        o_addr          = wr_addr;
                    end
                end
                OP_START: begin
                    n_next_slot = SLOT_W'(r_start_slot);
                    n_cur_slot  = SLOT_W'(r_start_slot);
                    n_pend      = PEND_NONE;
                    n_rem       = '0;
                    n_wif       = '0;
                    n_ci        = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_slot <= '0;
            r_next_slot  <= '0;
            r_cur_slot   <= '0;
            r_pend       <= PEND_NONE;
            r_rem        <= '0;
            r_wif        <= '0;
            r_ci         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_start_slot <= i_cfg_wdata;
            end
            r_next_slot <= n_next_slot;
            r_cur_slot  <= n_cur_slot;
            r_pend      <= n_pend;
            r_rem       <= n_rem;
            r_wif       <= n_wif;
            r_ci        <= n_ci;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bfr_queue.sv
`default_nettype none

module bfr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bfr_back.sv
`default_nettype none

module bfr_back #(
    parameter int DEPTH = 65536
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire bfr_pkg::t_qflags            i_flags,
    input  wire logic [bfr_pkg::WORD_W-1:0]  i_word,
    input  wire logic [$clog2(DEPTH)-1:0]    i_addr,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [bfr_pkg::WORD_W-1:0]       o_out_word,
    output logic                             o_far_rewritten,
    output logic                             o_clock_word_replaced,
    output logic                             o_table_or_device_fault
);
    import bfr_pkg::*;

    logic  r_valid;
    t_word r_word;
    logic  r_far;
    logic  r_clk;
    logic  r_fault;
    t_word ram_rdata;
    logic  ram_we;
    logic  ram_re;

    // Take the next request when the output slot is empty or being drained
    assign o_pop  = i_q_valid && (!r_valid || i_out_ready);
    assign ram_we = o_pop && i_flags.is_load;
    assign ram_re = o_pop && !i_flags.is_load && i_flags.rd_clk;

    bfr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_addr),
        .i_wdata (i_word),
        .i_re    (ram_re),
        .i_raddr (i_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= !i_flags.is_load;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_flags.is_load) begin
            r_word  <= i_word;
            r_far   <= i_flags.far;
            r_clk   <= i_flags.rd_clk;
            r_fault <= i_flags.fault;
        end
    end

    // Table data stays in the read register until the next read
    assign o_out_valid             = r_valid;
    assign o_out_word              = r_clk ? ram_rdata : r_word;
    assign o_far_rewritten         = r_far;
    assign o_clock_word_replaced   = r_clk;
    assign o_table_or_device_fault = r_fault;

endmodule

`default_nettype wire

>>> rtl/bitstream_frame_relocator.sv
// Channel   Handshake                  Payload
// in        i_in_valid / o_in_ready    i_operation, i_word, i_load_slot, i_load_index
// out       o_out_valid / i_out_ready  o_out_word, o_far_rewritten,
//                                      o_clock_word_replaced, o_table_or_device_fault
// cfg       i_cfg_we                   i_cfg_wdata (start slot)
//
// One request per cycle in while o_in_ready is high, one result per cycle out while
// i_out_ready is high; the front decodes into the queue, the back does the table read.
// The table is one write/read port RAM; loads and reads go through it in request order.
// Reset clears the start slot, the parser, the queue and the output stage; the table is not cleared.
// An output stall fills the request queue, then o_in_ready drops.
`default_nettype none

module bitstream_frame_relocator #(
    parameter int SLOT_COUNT            = bfr_pkg::SLOT_COUNT_DEF,
    parameter int CLOCK_WORDS_PER_SLOT  = bfr_pkg::CLOCK_WORDS_PER_SLOT_DEF,
    parameter int FRAME_WORDS           = bfr_pkg::FRAME_WORDS_DEF,
    parameter int CLOCK_WORDS_PER_FRAME = bfr_pkg::CLOCK_WORDS_PER_FRAME_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bfr_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [bfr_pkg::OP_W-1:0]         i_operation,
    input  wire logic [bfr_pkg::WORD_W-1:0]       i_word,
    input  wire logic [bfr_pkg::LOAD_SLOT_W-1:0]  i_load_slot,
    input  wire logic [bfr_pkg::LOAD_INDEX_W-1:0] i_load_index,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [bfr_pkg::WORD_W-1:0]            o_out_word,
    output logic                                  o_far_rewritten,
    output logic                                  o_clock_word_replaced,
    output logic                                  o_table_or_device_fault
);
    import bfr_pkg::*;

    localparam int TABLE_DEPTH = SLOT_COUNT * CLOCK_WORDS_PER_SLOT;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int QW          = $bits(t_qflags) + WORD_W + ADDR_W;

    logic              q_full;
    logic              push;
    t_qflags           push_flags;
    t_word             push_word;
    logic [ADDR_W-1:0] push_addr;
    logic [QW-1:0]     q_wdata;
    logic [QW-1:0]     q_rdata;
    logic              q_valid;
    logic              pop;
    t_qflags           pop_flags;
    t_word             pop_word;
    logic [ADDR_W-1:0] pop_addr;

    bfr_front #(
        .SLOT_COUNT            (SLOT_COUNT),
        .CLOCK_WORDS_PER_SLOT  (CLOCK_WORDS_PER_SLOT),
        .FRAME_WORDS           (FRAME_WORDS),
        .CLOCK_WORDS_PER_FRAME (CLOCK_WORDS_PER_FRAME),
        .ADDR_W                (ADDR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_word       (i_word),
        .i_load_slot  (i_load_slot),
        .i_load_index (i_load_index),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_flags      (push_flags),
        .o_word       (push_word),
        .o_addr       (push_addr)
    );

    assign q_wdata = {push_flags, push_word, push_addr};

    bfr_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata),
        .i_pop   (pop)
    );

    assign {pop_flags, pop_word, pop_addr} = q_rdata;

    bfr_back #(
        .DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_q_valid               (q_valid),
        .i_flags                 (pop_flags),
        .i_word                  (pop_word),
        .i_addr                  (pop_addr),
        .o_pop                   (pop),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_out_word              (o_out_word),
        .o_far_rewritten         (o_far_rewritten),
        .o_clock_word_replaced   (o_clock_word_replaced),
        .o_table_or_device_fault (o_table_or_device_fault)
    );

endmodule

`default_nettype wire

>>> rtl/bfr_props.sv
`default_nettype none

`include "bitstream_frame_relocator_macros.svh"

module bfr_props (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [bfr_pkg::WORD_W-1:0] o_out_word,
    input wire logic                       o_far_rewritten,
    input wire logic                       o_clock_word_replaced,
    input wire logic                       o_table_or_device_fault
);

    logic                         stall;
    logic [2:0]                   flags;
    logic [bfr_pkg::WORD_W+2:0]   result;

    assign stall  = o_out_valid && !i_out_ready;
    assign flags  = {o_far_rewritten, o_clock_word_replaced, o_table_or_device_fault};
    assign result = {o_out_word, flags};

    // A result is a frame address, a table word, a faulted word or none of these, never two
    `BFR_ASSERT_NOW(a_flags_exclusive, o_out_valid, $onehot0(flags), "more than one result flag")

    `BFR_ASSERT_NEXT(a_out_hold, stall, o_out_valid, "result dropped while stalled")

    `BFR_ASSERT_NEXT(a_out_stable, stall, $stable(result), "stalled result changed")

    `BFR_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_out_valid, "result right after reset")

endmodule

bind bitstream_frame_relocator bfr_props u_bfr_props (
    .i_clk                   (i_clk),
    .i_rst_n                 (i_rst_n),
    .o_out_valid             (o_out_valid),
    .i_out_ready             (i_out_ready),
    .o_out_word              (o_out_word),
    .o_far_rewritten         (o_far_rewritten),
    .o_clock_word_replaced   (o_clock_word_replaced),
    .o_table_or_device_fault (o_table_or_device_fault)
);

`default_nettype wire

>>> tb/bitstream_frame_relocator_tb.sv
`timescale 1ns / 1ps

module bitstream_frame_relocator_tb;

    import bfr_pkg::*;

    localparam int SLOTS          = SLOT_COUNT_DEF;
    localparam int CLK_PER_SLOT   = CLOCK_WORDS_PER_SLOT_DEF;
    localparam int FRAME_LEN      = FRAME_WORDS_DEF;
    localparam int CLK_PER_FRAME  = CLOCK_WORDS_PER_FRAME_DEF;
    localparam int CLK_FIRST      = (FRAME_LEN - CLK_PER_FRAME) / 2;
    localparam int TABLE_SIZE     = SLOTS * CLK_PER_SLOT;
    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_REQUESTS = 12;
    localparam int TIMEOUT_CYCLES = 100_000;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_BURSTY} t_rx_mode;

    typedef struct packed {
        t_word word;
        logic  far;
        logic  clk;
        logic  fault;
    } t_reloc_result;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_cfg_we     = 1'b0;
    logic [CFG_W-1:0]        i_cfg_wdata  = '0;
    logic                    i_in_valid   = 1'b0;
    logic [OP_W-1:0]         i_operation  = OP_STREAM;
    t_word                   i_word       = '0;
    logic [LOAD_SLOT_W-1:0]  i_load_slot  = '0;
    logic [LOAD_INDEX_W-1:0] i_load_index = '0;
    logic                    i_out_ready  = 1'b0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    t_word                   o_out_word;
    logic                    o_far_rewritten;
    logic                    o_clock_word_replaced;
    logic                    o_table_or_device_fault;

    // predictor state
    logic [CFG_W-1:0]  cfg_start_slot = '0;
    logic [SLOT_W-1:0] pr_next_slot;
    logic [SLOT_W-1:0] pr_cur_slot;
    logic [1:0]        pr_pending;
    int                pr_frames_left;
    int                pr_word_pos;
    int                pr_clock_index;
    t_word             table_copy [0:TABLE_SIZE-1];
    bit                table_written [0:TABLE_SIZE-1];

    t_reloc_result expected_rewrites [$];
    t_reloc_result oldest;
    int            mismatches = 0;
    int            items_sent = 0;

    // traffic shaping
    bit       sender_gaps  = 1'b1;
    int       burst_left   = 0;
    t_rx_mode rx_mode      = RX_RANDOM;
    int       rx_hold_req  = 0;
    int       rx_hold_left = 0;
    int       rx_run_left  = 0;
    bit       rx_stalled   = 1'b0;

    bitstream_frame_relocator dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_wdata             (i_cfg_wdata),
        .i_in_valid              (i_in_valid),
        .o_in_ready              (o_in_ready),
        .i_operation             (i_operation),
        .i_word                  (i_word),
        .i_load_slot             (i_load_slot),
        .i_load_index            (i_load_index),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_out_word              (o_out_word),
        .o_far_rewritten         (o_far_rewritten),
        .o_clock_word_replaced   (o_clock_word_replaced),
        .o_table_or_device_fault (o_table_or_device_fault)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void restart_parser();
        pr_next_slot   = {3'b000, cfg_start_slot};
        pr_cur_slot    = {3'b000, cfg_start_slot};
        pr_pending     = PEND_NONE;
        pr_frames_left = 0;
        pr_word_pos    = 0;
        pr_clock_index = 0;
    endfunction

    // Advance the predictor by one request; return 1 when it yields a result.
    function automatic bit relocate_request(input logic [OP_W-1:0] op, input t_word w,
                                            input logic [LOAD_SLOT_W-1:0] ls,
                                            input logic [LOAD_INDEX_W-1:0] li,
                                            output t_reloc_result r);
        r = '{word: w, far: 1'b0, clk: 1'b0, fault: 1'b0};
        if (op == OP_LOAD) begin
            table_copy[{ls, li}]    = w;
            table_written[{ls, li}] = 1'b1;
            return 1'b0;
        end
        if (op == OP_START) begin
            restart_parser();
            return 1'b0;
        end
        if (op != OP_STREAM)
            return 1'b0;

        if (pr_frames_left != 0) begin
            if (pr_word_pos >= CLK_FIRST && pr_word_pos < CLK_FIRST + CLK_PER_FRAME) begin
                if (pr_cur_slot < SLOTS) begin
                    r.word = table_copy[int'(pr_cur_slot) * CLK_PER_SLOT + pr_clock_index];
                    r.clk  = 1'b1;
                end else begin
                    r.fault = 1'b1;
                end
                pr_clock_index = (pr_clock_index + 1) % CLK_PER_SLOT;
            end
            pr_word_pos++;
            if (pr_word_pos >= FRAME_LEN) begin
                pr_word_pos = 0;
                pr_frames_left--;
            end
        end else begin
            case (pr_pending)
                PEND_ID: begin
                    pr_pending = PEND_NONE;
                    if (w == ID_PART_A)
                        pr_next_slot += ID_A_SLOT_OFFSET;
                    else if (w != ID_PART_B)
                        r.fault = 1'b1;
                end
                PEND_FAR: begin
                    pr_pending  = PEND_NONE;
                    pr_cur_slot = pr_next_slot;
                    if (w != FAR_END_MARK) begin
                        r.word = (w & ROW_KEEP_MASK) | (t_word'(pr_cur_slot) << ROW_SHIFT);
                        r.far  = 1'b1;
                        pr_next_slot++;
                    end
                end
                PEND_COUNT: begin
                    pr_pending     = PEND_NONE;
                    pr_frames_left = int'((w & TYPE2_COUNT_MASK) / FRAME_LEN);
                    pr_word_pos    = 0;
                end
                default: begin
                    if (w == CMD_FAR) begin
                        pr_pending = PEND_FAR;
                    end else if ((w & FDRI_HDR_MASK) == CMD_FDRI) begin
                        if ((w & TYPE1_COUNT_MASK) != 0) begin
                            pr_frames_left = int'((w & TYPE1_COUNT_MASK) / FRAME_LEN);
                            pr_word_pos    = 0;
                        end else begin
                            pr_pending = PEND_COUNT;
                        end
                    end else if (w == CMD_DEVICE_ID) begin
                        pr_pending = PEND_ID;
                    end
                end
            endcase
        end
        return 1'b1;
    endfunction

    // 1 when the next stream word reads the clock table; addr gives the entry
    function automatic bit clock_read_pending(output int addr);
        addr = int'(pr_cur_slot) * CLK_PER_SLOT + pr_clock_index;
        return pr_frames_left != 0 && pr_word_pos >= CLK_FIRST
            && pr_word_pos < CLK_FIRST + CLK_PER_FRAME && pr_cur_slot < SLOTS;
    endfunction

    task automatic push_request(input logic [OP_W-1:0] op, input t_word w,
                                input logic [LOAD_SLOT_W-1:0] ls,
                                input logic [LOAD_INDEX_W-1:0] li);
        t_reloc_result res;
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_operation  = op;
        i_word       = w;
        i_load_slot  = ls;
        i_load_index = li;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        if (relocate_request(op, w, ls, li, res))
            expected_rewrites.push_back(res);
        if (op != OP_UNUSED)
            items_sent++;
        if (sender_gaps) begin
            if (burst_left == 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Load the clock entry first when the word would read one never written, and now and then also when it was.
    task automatic stream_word(input t_word w);
        int addr;
        if (clock_read_pending(addr) && (!table_written[addr] || $urandom_range(0, 7) == 0))
            push_request(OP_LOAD, $urandom, 3'(addr / CLK_PER_SLOT),
                         13'(addr % CLK_PER_SLOT));
        push_request(OP_STREAM, w, 3'($urandom), 13'($urandom));
    endtask

    task automatic send_command(input t_word cmd, input t_word operand);
        stream_word(cmd);
        stream_word(operand);
    endtask

    task automatic send_fdri(input int count, input bit type2);
        if (type2) begin
            stream_word(CMD_FDRI | (t_word'($urandom_range(0, 15)) << 10));
            stream_word({8'($urandom), 24'(count)});
        end else begin
            stream_word(CMD_FDRI | (t_word'($urandom_range(0, 15)) << 10)
                        | t_word'(count % 1024));
        end
    endtask

    // Frame data, sprinkled with command words that must not be parsed as commands.
    task automatic send_frame_words(input int n);
        repeat (n) begin
            case ($urandom_range(0, 19))
                0:       stream_word(CMD_FAR);
                1:       stream_word(CMD_DEVICE_ID);
                2:       stream_word(CMD_FDRI | t_word'($urandom_range(1, 200)));
                default: stream_word($urandom);
            endcase
        end
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_rewrites.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the start slot while idle, then apply it with a start request.
    task automatic set_start_slot(input logic [CFG_W-1:0] slot);
        wait_for_drain();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = slot;
        @(negedge i_clk);
        i_cfg_we       = 1'b0;
        cfg_start_slot = slot;
        push_request(OP_START, $urandom, 3'($urandom), 13'($urandom));
    endtask

    task automatic report_mismatch(input string what, input t_word want, input t_word got);
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    task automatic test_directed_cases();
        set_start_slot(3'd0);
        push_request(OP_UNUSED, '1, '1, '1);
        stream_word('0);
        stream_word('1);
        send_command(CMD_DEVICE_ID, ID_PART_A);
        send_command(CMD_DEVICE_ID, ID_PART_B);
        // unknown ID that looks like a command: fault, not parsed
        send_command(CMD_DEVICE_ID, CMD_FAR);
        send_command(CMD_FAR, '1);
        send_command(CMD_FAR, FAR_END_MARK);
        send_command(CMD_FAR, CMD_DEVICE_ID);
        send_fdri(FRAME_LEN - 1, 1'b0);
        send_fdri(FRAME_LEN - 1, 1'b1);
        push_request(OP_LOAD, '1, 3'd7, 13'h1FFF);
        push_request(OP_LOAD, '0, 3'd0, 13'd0);
        push_request(OP_START, '0, '0, '0);
        send_command(CMD_FAR, '0);
    endtask

    task automatic test_frame_relocation();
        rx_mode = RX_RANDOM;
        set_start_slot(3'd3);
        send_command(CMD_DEVICE_ID, ID_PART_B);
        send_command(CMD_FAR, $urandom);
        send_fdri(FRAME_LEN, 1'b0);
        send_frame_words(FRAME_LEN);
        send_command(CMD_FAR, FAR_END_MARK);
        send_fdri(FRAME_LEN + 5, 1'b1);
        send_frame_words(FRAME_LEN);
        stream_word($urandom);
        // slot past the table: clock words pass with the fault flag
        rx_mode = RX_BURSTY;
        set_start_slot(3'd7);
        send_command(CMD_DEVICE_ID, ID_PART_A);
        send_command(CMD_FAR, $urandom);
        send_fdri(FRAME_LEN, 1'b0);
        send_frame_words(CLK_FIRST + CLK_PER_FRAME);
    endtask

    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        rx_mode     = RX_ALWAYS;
        set_start_slot(3'($urandom_range(1, 6)));
        // hold the output long enough for the input side to stall
        rx_hold_req = LONG_HOLD;
        repeat (16) stream_word($urandom);
        repeat (8) send_command(CMD_FAR, $urandom);
        wait_for_drain();
    endtask

    task automatic test_random_streams();
        int target;
        int choice;
        for (int p = 0; p < 5; p++) begin
            sender_gaps = (p != 2);
            rx_mode     = (p == 2) ? RX_ALWAYS : t_rx_mode'($urandom_range(1, 2));
            set_start_slot(p == 0 ? 3'd0 : p == 1 ? 3'd7 : 3'($urandom_range(0, 7)));
            target = items_sent + PHASE_REQUESTS;
            while (items_sent < target) begin
                choice = $urandom_range(0, 99);
                if (pr_frames_left != 0 && $urandom_range(0, 59) != 0) begin
                    send_frame_words(1);
                end else if (choice < 30) begin
                    stream_word(CMD_FAR);
                    if ($urandom_range(0, 9) != 0)
                        stream_word($urandom_range(0, 9) == 0 ? FAR_END_MARK : $urandom);
                end else if (choice < 45) begin
                    stream_word(CMD_DEVICE_ID);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: stream_word(ID_PART_A);
                        4, 5, 6:    stream_word(ID_PART_B);
                        8:          ;
                        default:    stream_word($urandom);
                    endcase
                end else if (choice < 60) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: send_fdri($urandom_range(1, FRAME_LEN - 1), 1'b0);
                        6, 7:             send_fdri($urandom_range(FRAME_LEN, 200), 1'b0);
                        8:                send_fdri($urandom_range(0, 200), 1'b1);
                        default:          stream_word(CMD_FDRI);
                    endcase
                end else if (choice < 75) begin
                    push_request(OP_LOAD, $urandom, 3'($urandom), 13'($urandom));
                end else if (choice < 90) begin
                    stream_word($urandom);
                end else if (choice < 94) begin
                    push_request(OP_START, $urandom, 3'($urandom), 13'($urandom));
                end else if (choice < 97) begin
                    push_request(OP_UNUSED, $urandom, 3'($urandom), 13'($urandom));
                end else begin
                    wait_for_drain();
                end
            end
        end
    endtask

    task automatic test_slot_wrap();
        sender_gaps = 1'b0;
        rx_mode     = RX_ALWAYS;
        set_start_slot(3'd7);
        send_command(CMD_DEVICE_ID, ID_PART_A);
        send_command(CMD_FAR, $urandom);
        // step the slot on until it wraps back into the table
        while (pr_next_slot >= SLOTS)
            send_command(CMD_DEVICE_ID, ID_PART_A);
        send_command(CMD_FAR, $urandom);
    endtask

    always @(negedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_out_ready = 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_out_ready = 1'b1;
                RX_RANDOM: i_out_ready = ($urandom_range(0, 3) != 0);
                default: begin
                    if (rx_run_left == 0) begin
                        rx_stalled  = !rx_stalled;
                        rx_run_left = rx_stalled ? $urandom_range(1, 12) : $urandom_range(1, 6);
                    end else begin
                        rx_run_left--;
                    end
                    i_out_ready = !rx_stalled;
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rewrites.size() == 0) begin
                report_mismatch("unexpected result, word", '0, o_out_word);
            end else begin
                oldest = expected_rewrites.pop_front();
                if (o_out_word !== oldest.word)
                    report_mismatch("out_word", oldest.word, o_out_word);
                if (o_far_rewritten !== oldest.far)
                    report_mismatch("far_rewritten", t_word'(oldest.far),
                                    t_word'(o_far_rewritten));
                if (o_clock_word_replaced !== oldest.clk)
                    report_mismatch("clock_word_replaced", t_word'(oldest.clk),
                                    t_word'(o_clock_word_replaced));
                if (o_table_or_device_fault !== oldest.fault)
                    report_mismatch("table_or_device_fault", t_word'(oldest.fault),
                                    t_word'(o_table_or_device_fault));
            end
        end
    end

    initial begin
        restart_parser();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_frame_relocation();
        test_output_backpressure();
        test_random_streams();
        test_slot_wrap();

        wait_for_drain();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bfr_pkg.sv
rtl/bfr_ram.sv
rtl/bfr_front.sv
rtl/bfr_queue.sv
rtl/bfr_back.sv
rtl/bitstream_frame_relocator.sv
rtl/bfr_props.sv
tb/bitstream_frame_relocator_tb.sv
